@@ rtl/lsbspi_pkg.sv @@
package lsbspi_pkg;

  localparam int WAIT_W = 24;
  localparam int HALF_W = 8;
  localparam int CFG_W  = (WAIT_W > HALF_W) ? WAIT_W : HALF_W;

  localparam logic [0:0] CFG_WAIT_TICKS = 1'b0;
  localparam logic [0:0] CFG_SCK_HALF   = 1'b1;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_READ     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_ENTER    = 3'd3;
  localparam logic [2:0] CMD_LEAVE    = 3'd4;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

  localparam logic [1:0] OP_READ  = 2'b01;
  localparam logic [1:0] OP_WRITE = 2'b10;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SHUT_W,
    PH_ENT_W1,
    PH_ENT_W2,
    PH_ENT_W3,
    PH_LEAVE_W,
    PH_RD_CMD,
    PH_RD_FF,
    PH_RD_FETCH,
    PH_WR_CMD,
    PH_WR_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  reg_index;
    logic [31:0] write_data;
    logic [2:0]  read_length;
    logic        force_req;
    logic        miso;
  } in_t;

  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        ss;
    logic        xx_pin;
    logic        ej_pin;
    logic        busy_res;
    logic        read_valid;
    logic [31:0] read_data;
    logic        in_flash_mode;
  } out_t;

endpackage

@@ rtl/lsb_first_spi_flash_port_master.sv @@
// Each accepted input transfer is one sequencer tick; its result (pin levels and
// status after that tick) is registered into the output buffer.
// Throughput: one tick per cycle while the output buffer has room (in_ready).
// A two-entry output buffer keeps input ready while one result waits.
// Reset (synchronous, active low): idle, SS and EJ high, SCK/MOSI/XX low,
// flash mode clear, wait_ticks = 50000, sck_half_ticks = 1.
module lsb_first_spi_flash_port_master (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lsbspi_pkg::in_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lsbspi_pkg::out_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [lsbspi_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [lsbspi_pkg::WAIT_W-1:0] wait_ticks_r;
  logic [lsbspi_pkg::HALF_W-1:0] sck_half_r;

  lsbspi_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [31:0] read_accum_r, read_accum_nxt;
  logic [lsbspi_pkg::WAIT_W-1:0] wait_count_r, wait_count_nxt;
  logic [lsbspi_pkg::HALF_W-1:0] half_count_r, half_count_nxt;
  logic        flag_r, flag_nxt;
  logic        sck_r, sck_nxt;
  logic        mosi_r, mosi_nxt;
  logic        ss_r, ss_nxt;
  logic        xx_r, xx_nxt;
  logic        ej_r, ej_nxt;
  logic [2:0]  fetch_len_r, fetch_len_nxt;
  logic        read_valid_nxt;

  logic        in_fire;
  logic [lsbspi_pkg::WAIT_W-1:0] wait_load;
  logic [lsbspi_pkg::HALF_W-1:0] half_load;
  logic        wait_done;
  logic        half_done;
  logic        byte_end;
  logic [2:0]  byte_inc;
  logic        leave_ok;
  logic [7:0]  shift_new;
  logic        byte_start;
  logic [7:0]  byte_val;
  logic        byte_fetch;
  lsbspi_pkg::out_t result;
  logic        res_ready;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = res_ready;
  assign wait_load = (wait_ticks_r == '0) ? '0 : wait_ticks_r - 1'b1;
  assign half_load = (sck_half_r == '0) ? '0 : sck_half_r - 1'b1;
  assign wait_done = (wait_count_r == '0);
  assign half_done = (half_count_r == '0);
  assign byte_end  = half_done && sck_r && (bit_count_r == 3'd7);
  assign byte_inc  = byte_count_r + 3'd1;
  assign leave_ok  = flag_r || in_data.force_req;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      lsbspi_pkg::PH_IDLE: begin
        case (in_data.command)
          lsbspi_pkg::CMD_READ:     phase_nxt = lsbspi_pkg::PH_RD_CMD;
          lsbspi_pkg::CMD_WRITE:    phase_nxt = lsbspi_pkg::PH_WR_CMD;
          lsbspi_pkg::CMD_ENTER:    phase_nxt = lsbspi_pkg::PH_ENT_W1;
          lsbspi_pkg::CMD_LEAVE:    if (leave_ok) phase_nxt = lsbspi_pkg::PH_LEAVE_W;
          lsbspi_pkg::CMD_SHUTDOWN: phase_nxt = lsbspi_pkg::PH_SHUT_W;
          default:                  phase_nxt = lsbspi_pkg::PH_IDLE;
        endcase
      end
      lsbspi_pkg::PH_SHUT_W:  if (wait_done) phase_nxt = lsbspi_pkg::PH_IDLE;
      lsbspi_pkg::PH_ENT_W1:  if (wait_done) phase_nxt = lsbspi_pkg::PH_ENT_W2;
      lsbspi_pkg::PH_ENT_W2:  if (wait_done) phase_nxt = lsbspi_pkg::PH_ENT_W3;
      lsbspi_pkg::PH_ENT_W3:  if (wait_done) phase_nxt = lsbspi_pkg::PH_IDLE;
      lsbspi_pkg::PH_LEAVE_W: if (wait_done) phase_nxt = lsbspi_pkg::PH_IDLE;
      lsbspi_pkg::PH_RD_CMD:  if (byte_end) phase_nxt = lsbspi_pkg::PH_RD_FF;
      lsbspi_pkg::PH_RD_FF:   if (byte_end) phase_nxt = lsbspi_pkg::PH_RD_FETCH;
      lsbspi_pkg::PH_RD_FETCH: begin
        if (byte_end && (byte_inc >= fetch_len_r)) phase_nxt = lsbspi_pkg::PH_IDLE;
      end
      lsbspi_pkg::PH_WR_CMD:  if (byte_end) phase_nxt = lsbspi_pkg::PH_WR_DATA;
      lsbspi_pkg::PH_WR_DATA: begin
        if (byte_end && (byte_count_r == 3'd0)) phase_nxt = lsbspi_pkg::PH_IDLE;
      end
      default: phase_nxt = lsbspi_pkg::PH_IDLE;
    endcase
  end

  // pins, counters and shift data
  always_comb begin
    bit_count_nxt  = bit_count_r;
    byte_count_nxt = byte_count_r;
    shift_byte_nxt = shift_byte_r;
    read_accum_nxt = read_accum_r;
    wait_count_nxt = wait_count_r;
    half_count_nxt = half_count_r;
    flag_nxt       = flag_r;
    sck_nxt        = sck_r;
    mosi_nxt       = mosi_r;
    ss_nxt         = ss_r;
    xx_nxt         = xx_r;
    ej_nxt         = ej_r;
    fetch_len_nxt  = fetch_len_r;
    read_valid_nxt = 1'b0;
    byte_start     = 1'b0;
    byte_val       = 8'h00;
    byte_fetch     = 1'b0;
    shift_new      = shift_byte_r;
    if (phase_r == lsbspi_pkg::PH_RD_FETCH) shift_new[bit_count_r] = in_data.miso;

    case (phase_r)
      lsbspi_pkg::PH_IDLE: begin
        case (in_data.command)
          lsbspi_pkg::CMD_READ: begin
            if (in_data.read_length == 3'd0)     fetch_len_nxt = 3'd1;
            else if (in_data.read_length > 3'd4) fetch_len_nxt = 3'd4;
            else                                 fetch_len_nxt = in_data.read_length;
            read_accum_nxt = '0;
            ss_nxt         = 1'b0;
            byte_start     = 1'b1;
            byte_val       = {in_data.reg_index, lsbspi_pkg::OP_READ};
          end
          lsbspi_pkg::CMD_WRITE: begin
            read_accum_nxt = in_data.write_data;
            ss_nxt         = 1'b0;
            byte_start     = 1'b1;
            byte_val       = {in_data.reg_index, lsbspi_pkg::OP_WRITE};
          end
          lsbspi_pkg::CMD_ENTER: begin
            xx_nxt         = 1'b0;
            wait_count_nxt = wait_load;
          end
          lsbspi_pkg::CMD_LEAVE: begin
            if (leave_ok) begin
              ss_nxt         = 1'b1;
              ej_nxt         = 1'b0;
              wait_count_nxt = wait_load;
            end
          end
          lsbspi_pkg::CMD_SHUTDOWN: begin
            ss_nxt         = 1'b1;
            xx_nxt         = 1'b0;
            ej_nxt         = 1'b0;
            wait_count_nxt = wait_load;
          end
          default: ;
        endcase
      end
      lsbspi_pkg::PH_SHUT_W, lsbspi_pkg::PH_ENT_W1, lsbspi_pkg::PH_ENT_W2,
      lsbspi_pkg::PH_ENT_W3, lsbspi_pkg::PH_LEAVE_W: begin
        if (!wait_done) begin
          wait_count_nxt = wait_count_r - 1'b1;
        end else begin
          case (phase_r)
            lsbspi_pkg::PH_SHUT_W: ej_nxt = 1'b1;
            lsbspi_pkg::PH_ENT_W1: begin
              ss_nxt         = 1'b0;
              ej_nxt         = 1'b0;
              wait_count_nxt = wait_load;
            end
            lsbspi_pkg::PH_ENT_W2: begin
              xx_nxt         = 1'b1;
              ej_nxt         = 1'b1;
              wait_count_nxt = wait_load;
            end
            lsbspi_pkg::PH_ENT_W3: begin
              ss_nxt   = 1'b0;
              flag_nxt = 1'b1;
            end
            default: begin
              xx_nxt   = 1'b0;
              ej_nxt   = 1'b1;
              flag_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        if (!half_done) begin
          half_count_nxt = half_count_r - 1'b1;
        end else if (!sck_r) begin
          sck_nxt        = 1'b1;
          half_count_nxt = half_load;
        end else begin
          // falling edge: MISO already captured into shift_new
          shift_byte_nxt = shift_new;
          sck_nxt        = 1'b0;
          bit_count_nxt  = bit_count_r + 3'd1;
          if (bit_count_r != 3'd7) begin
            mosi_nxt = (phase_r != lsbspi_pkg::PH_RD_FETCH) && shift_new[bit_count_nxt];
            half_count_nxt = half_load;
          end else begin
            case (phase_r)
              lsbspi_pkg::PH_RD_CMD: begin
                byte_start = 1'b1;
                byte_val   = lsbspi_pkg::DUMMY_BYTE;
              end
              lsbspi_pkg::PH_RD_FF: begin
                byte_count_nxt = 3'd0;
                byte_start     = 1'b1;
                byte_fetch     = 1'b1;
              end
              lsbspi_pkg::PH_RD_FETCH: begin
                read_accum_nxt = read_accum_r
                               | ({24'h0, shift_new} << {byte_count_r[1:0], 3'b000});
                byte_count_nxt = byte_inc;
                if (byte_inc >= fetch_len_r) begin
                  ss_nxt         = 1'b1;
                  read_valid_nxt = 1'b1;
                end else begin
                  byte_start = 1'b1;
                  byte_fetch = 1'b1;
                end
              end
              lsbspi_pkg::PH_WR_CMD: begin
                byte_count_nxt = 3'd3;
                byte_start     = 1'b1;
                byte_val       = read_accum_r[7:0];
                read_accum_nxt = read_accum_r >> 8;
              end
              default: begin
                if (byte_count_r == 3'd0) begin
                  ss_nxt = 1'b1;
                end else begin
                  byte_count_nxt = byte_count_r - 3'd1;
                  byte_start     = 1'b1;
                  byte_val       = read_accum_r[7:0];
                  read_accum_nxt = read_accum_r >> 8;
                end
              end
            endcase
          end
        end
      end
    endcase

    // new byte opens with SCK low and bit 0 on MOSI (MOSI low for a fetch byte)
    if (byte_start) begin
      shift_byte_nxt = byte_val;
      bit_count_nxt  = 3'd0;
      sck_nxt        = 1'b0;
      mosi_nxt       = !byte_fetch && byte_val[0];
      half_count_nxt = half_load;
    end
  end

  always_comb begin
    result.sck           = sck_nxt;
    result.mosi          = mosi_nxt;
    result.ss            = ss_nxt;
    result.xx_pin        = xx_nxt;
    result.ej_pin        = ej_nxt;
    result.busy_res      = (phase_nxt != lsbspi_pkg::PH_IDLE);
    result.read_valid    = read_valid_nxt;
    result.read_data     = read_valid_nxt ? read_accum_nxt : 32'h0;
    result.in_flash_mode = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= lsbspi_pkg::WAIT_W'(50000);
      sck_half_r   <= lsbspi_pkg::HALF_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        lsbspi_pkg::CFG_WAIT_TICKS: wait_ticks_r <= cfg_wdata[lsbspi_pkg::WAIT_W-1:0];
        lsbspi_pkg::CFG_SCK_HALF:   sck_half_r   <= cfg_wdata[lsbspi_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lsbspi_pkg::PH_IDLE;
      bit_count_r  <= '0;
      byte_count_r <= '0;
      shift_byte_r <= '0;
      read_accum_r <= '0;
      wait_count_r <= '0;
      half_count_r <= '0;
      flag_r       <= 1'b0;
      sck_r        <= 1'b0;
      mosi_r       <= 1'b0;
      ss_r         <= 1'b1;
      xx_r         <= 1'b0;
      ej_r         <= 1'b1;
      fetch_len_r  <= 3'd1;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      byte_count_r <= byte_count_nxt;
      shift_byte_r <= shift_byte_nxt;
      read_accum_r <= read_accum_nxt;
      wait_count_r <= wait_count_nxt;
      half_count_r <= half_count_nxt;
      flag_r       <= flag_nxt;
      sck_r        <= sck_nxt;
      mosi_r       <= mosi_nxt;
      ss_r         <= ss_nxt;
      xx_r         <= xx_nxt;
      ej_r         <= ej_nxt;
      fetch_len_r  <= fetch_len_nxt;
    end
  end

  lsbspi_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (res_ready),
    .in_data   (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/lsbspi_skid.sv @@
module lsbspi_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsbspi_pkg::out_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lsbspi_pkg::out_t  out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  lsbspi_pkg::out_t main_r, main_nxt;
  lsbspi_pkg::out_t skid_r, skid_nxt;
  logic             push;
  logic             pop;

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = push;
        skid_nxt       = in_data;
      end else begin
        main_valid_nxt = push;
        main_nxt       = in_data;
      end
    end else if (push) begin
      // output stalled: park the transfer in the skid slot
      skid_valid_nxt = 1'b1;
      skid_nxt       = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ rtl/lsbspi_checker.sv @@
module lsbspi_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input lsbspi_pkg::out_t out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |-> out_data.read_data == 32'h0)
    else $error("read_data nonzero without read_valid");

  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.ss && !out_data.sck && !out_data.busy_res)
    else $error("read completion without SS high and idle");

  // SCK toggles only inside a selected transfer
  a_sck_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sck |-> out_data.busy_res && !out_data.ss)
    else $error("SCK high outside a transfer");

endmodule

bind lsb_first_spi_flash_port_master lsbspi_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
